// ----- rtl/rfp_pkg.sv -----
package rfp_pkg;

    localparam int BUF_SIZE_DEF = 256;
    localparam int LINE_MAX_DEF = 256;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_MAX_PAYLOAD = 1'b0;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd240;

    localparam logic [11:0] ACC_MAX = 12'hFFF;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [2:0] TAG_LEN = 3'd5;

    typedef struct packed {
        logic [7:0] line_char;
        logic       end_of_line;
    } rfp_in_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
        logic [7:0] clamped_len;
    } rfp_out_t;

    // "+RCV=" one character per position
    function automatic logic [7:0] rcv_tag_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h52;
            3'd2:    ch = 8'h43;
            3'd3:    ch = 8'h56;
            3'd4:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/rfp_parser.sv -----
module rfp_parser
    import rfp_pkg::*;
#(
    parameter int BUF_SIZE = BUF_SIZE_DEF,
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  rfp_in_t    in_data,
    input  logic [7:0] max_payload,
    output logic       res_push,
    output rfp_out_t   res_data
);

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_ADDR   = 3'd1,
        PH_LSTART = 3'd2,
        PH_DIGITS = 3'd3,
        PH_SEEK2  = 3'd4,
        PH_EMIT   = 3'd5,
        PH_IGNORE = 3'd6
    } phase_t;

    localparam logic [7:0]  LINE_LAST = 8'(LINE_MAX - 1);
    localparam logic [11:0] BUF_LIM   = 12'(BUF_SIZE);
    localparam logic [7:0]  LEN_CLAMP = 8'(BUF_SIZE - 1);

    phase_t      phase_reg, phase_next;
    logic [2:0]  prefix_pos_reg, prefix_pos_next;
    logic [11:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  line_pos_reg, line_pos_next;
    logic [7:0]  frame_len_reg, frame_len_next;

    logic [7:0]  c;
    logic        is_digit, is_space, owe_bytes, seek_comma;
    logic [3:0]  digit;
    logic [15:0] acc_x10;
    logic [11:0] sat_lim, acc_digit;
    logic [7:0]  clamp_len;
    logic        start_ok;

    assign c         = in_data.line_char;
    assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_space  = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign digit     = c[3:0];
    assign owe_bytes = (phase_reg == PH_EMIT) && (rem_reg != 8'd0);

    // saturating acc*10+d; (4095-d)/10 is 409 for d<=5, else 408
    assign acc_x10   = 16'(acc_reg) * 16'd10 + 16'(digit);
    assign sat_lim   = (digit <= 4'd5) ? 12'd409 : 12'd408;
    assign acc_digit = (acc_reg > sat_lim) ? ACC_MAX : acc_x10[11:0];

    assign clamp_len = (acc_reg >= BUF_LIM) ? LEN_CLAMP : acc_reg[7:0];
    assign start_ok  = !neg_reg && (acc_reg != 12'd0) && (clamp_len <= max_payload);

    always_comb
    begin
        phase_next      = phase_reg;
        prefix_pos_next = prefix_pos_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        line_pos_next   = line_pos_reg;
        frame_len_next  = frame_len_reg;
        seek_comma      = 1'b0;
        res_push        = 1'b0;
        res_data.payload_byte = 8'd0;
        res_data.byte_valid   = 1'b0;
        res_data.last         = 1'b1;
        res_data.clamped_len  = frame_len_reg;

        if (in_fire)
        begin
            if (in_data.end_of_line)
            begin
                res_push        = owe_bytes;
                phase_next      = PH_PREFIX;
                prefix_pos_next = 3'd0;
                acc_next        = 12'd0;
                neg_next        = 1'b0;
                rem_next        = 8'd0;
                line_pos_next   = 8'd0;
            end
            else if (line_pos_reg < LINE_LAST)
            begin
                line_pos_next = line_pos_reg + 8'd1;
                if (c == CHAR_NUL)
                begin
                    // NUL ends the line text; close an open frame short
                    res_push   = owe_bytes;
                    phase_next = PH_IGNORE;
                    rem_next   = 8'd0;
                end
                else
                begin
                    case (phase_reg)
                        PH_PREFIX:
                        begin
                            if (prefix_pos_reg < TAG_LEN && c == rcv_tag_char(prefix_pos_reg))
                            begin
                                prefix_pos_next = prefix_pos_reg + 3'd1;
                                if (prefix_pos_reg == TAG_LEN - 3'd1)
                                    phase_next = PH_ADDR;
                            end
                            else
                                phase_next = PH_IGNORE;
                        end
                        PH_ADDR:
                        begin
                            if (c == CHAR_COMMA)
                                phase_next = PH_LSTART;
                        end
                        PH_LSTART:
                        begin
                            if (is_space)
                                phase_next = PH_LSTART;
                            else if (c == CHAR_PLUS || c == CHAR_MINUS)
                            begin
                                neg_next   = (c == CHAR_MINUS);
                                phase_next = PH_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = acc_digit;
                                phase_next = PH_DIGITS;
                            end
                            else
                                seek_comma = 1'b1;
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                                acc_next = acc_digit;
                            else
                                seek_comma = 1'b1;
                        end
                        PH_SEEK2:
                            seek_comma = 1'b1;
                        PH_EMIT:
                        begin
                            if (rem_reg == 8'd0)
                                phase_next = PH_IGNORE;
                            else
                            begin
                                rem_next              = rem_reg - 8'd1;
                                res_push              = 1'b1;
                                res_data.payload_byte = c;
                                res_data.byte_valid   = 1'b1;
                                res_data.last         = (rem_reg == 8'd1);
                                if (rem_reg == 8'd1)
                                    phase_next = PH_IGNORE;
                            end
                        end
                        default:
                            phase_next = phase_reg;
                    endcase

                    if (seek_comma)
                    begin
                        phase_next = PH_SEEK2;
                        if (c == CHAR_COMMA)
                        begin
                            if (start_ok)
                            begin
                                frame_len_next = clamp_len;
                                rem_next       = clamp_len;
                                phase_next     = PH_EMIT;
                            end
                            else
                                phase_next = PH_IGNORE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PREFIX;
            prefix_pos_reg <= 3'd0;
            acc_reg        <= 12'd0;
            neg_reg        <= 1'b0;
            rem_reg        <= 8'd0;
            line_pos_reg   <= 8'd0;
            frame_len_reg  <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            prefix_pos_reg <= prefix_pos_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            rem_reg        <= rem_next;
            line_pos_reg   <= line_pos_next;
            frame_len_reg  <= frame_len_next;
        end
    end

    a_emit_owes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EMIT |-> rem_reg != 8'd0)
        else $error("emit phase with nothing owed");

    a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_pos_reg <= TAG_LEN)
        else $error("prefix position out of range");

    a_short_close: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res_data.byte_valid) |-> (res_data.last && res_data.payload_byte == 8'd0))
        else $error("empty result without last flag");

endmodule

// ----- rtl/rfp_out_buf.sv -----
module rfp_out_buf
    import rfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rfp_out_t push_data,
    output logic     full,
    output logic     out_valid,
    input  logic     out_ready,
    output rfp_out_t out_data
);

    logic [1:0] count_reg;
    rfp_out_t   head_reg, tail_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_reg + 2'(push) - 2'(pop);
    end

    // head always holds the oldest transaction
    always_ff @(posedge clk)
    begin
        if (push && (count_reg == 2'd0 || (count_reg == 2'd1 && pop)))
            head_reg <= push_data;
        else if (pop && count_reg == 2'd2)
            head_reg <= tail_reg;
        if (push && count_reg == 2'd1 && !pop)
            tail_reg <= push_data;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("buffer count overflow");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full buffer");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1 && pop && !push) |=> !out_valid)
        else $error("buffer did not drain");

endmodule

// ----- rtl/rcv_frame_payload_parser.sv -----
// Receive-line payload parser.
// Input channel (in_valid/in_ready/in_data): one character of a response line
// per transaction, or an end-of-line marker. Lines starting "+RCV=" are
// parsed: the length after the first comma is read, clamped and checked
// against max_payload, then the bytes after the second comma come out.
// Output channel (out_valid/out_ready/out_data): one transaction per payload
// byte, last set on the final one; a line that ends early yields one
// transaction with byte_valid low and last set.
// APB port: register 0 at address 0 is max_payload (reset 240).
// A result is decided combinationally from the input transaction that causes
// it and registered in the output buffer. Throughput: one input transaction
// per cycle while in_ready is high; the parse state and the per-character
// decision sit between the input and a two-entry output buffer.
// When the receiver stalls the buffer fills; in_ready drops only once it
// holds two results, so parsing stalls with no loss.
// Reset clears the parse state, empties the buffer and restores max_payload.
module rcv_frame_payload_parser
    import rfp_pkg::*;
#(
    parameter int BUF_SIZE = BUF_SIZE_DEF,
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rfp_in_t            in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rfp_out_t           out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       rd_hit;
    logic [7:0] max_payload_reg;
    logic       in_fire, res_push, buf_full;
    rfp_out_t   res_data;
    logic [PADDR_W-3:0] reg_index;

    assign reg_index = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RST;
        else if (psel && penable && pwrite && reg_index == REG_MAX_PAYLOAD)
            max_payload_reg <= pwdata[7:0];
    end

    assign rd_hit = (reg_index == REG_MAX_PAYLOAD);
    assign prdata = rd_hit ? {24'd0, max_payload_reg} : 32'd0;

    assign in_ready = !buf_full;
    assign in_fire  = in_valid && in_ready;

    rfp_parser #(
        .BUF_SIZE (BUF_SIZE),
        .LINE_MAX (LINE_MAX)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_data     (in_data),
        .max_payload (max_payload_reg),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    rfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- tb/sv/rcv_frame_payload_parser_tb.sv -----
`timescale 1ns / 100ps

module rcv_frame_payload_parser_tb;

    import rfp_pkg::*;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [39:0] RCV_TAG = "+RCV=";
    localparam logic [PADDR_W-1:0] MAX_PAYLOAD_ADDR = {REG_MAX_PAYLOAD, 2'b00};

    typedef enum logic [2:0]
    {
        SCAN_TAG,
        SKIP_ADDR,
        LEN_START,
        LEN_DIGITS,
        SEEK_COMMA,
        EMIT_BYTES,
        DISCARD
    } parse_phase_e;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    rfp_in_t            in_data;
    logic               out_valid;
    logic               out_ready;
    rfp_out_t           out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // model of the parser
    logic [7:0]   cfg_max_len;
    parse_phase_e ph;
    logic [2:0]   tag_idx;
    logic [11:0]  len_acc;
    logic         len_neg;
    logic [7:0]   owed;
    logic [7:0]   chars_kept;
    logic [7:0]   frame_len;

    rfp_out_t   pending_payload[$];
    logic [7:0] line_buf[$];

    int  errors;
    int  items_sent;
    int  rx_wait;
    bit  rx_hold_req;
    bit  tx_idle_on;
    bit  rx_idle_on;

    rcv_frame_payload_parser DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    //--------------------------------------------------------------------
    // Parser model
    //--------------------------------------------------------------------
    function automatic void clear_line();
        ph         = SCAN_TAG;
        tag_idx    = '0;
        len_acc    = '0;
        len_neg    = 1'b0;
        owed       = '0;
        chars_kept = '0;
    endfunction

    function automatic void emit_payload(logic [7:0] b, logic v, logic l);
        rfp_out_t r;
        r.payload_byte = b;
        r.byte_valid   = v;
        r.last         = l;
        r.clamped_len  = frame_len;
        pending_payload.push_back(r);
    endfunction

    function automatic void add_len_digit(logic [7:0] c);
        int d;
        d = int'(c - CHAR_ZERO);
        if (int'(len_acc) > (int'(ACC_MAX) - d) / 10)
            len_acc = ACC_MAX;
        else
            len_acc = 12'(int'(len_acc) * 10 + d);
    endfunction

    // second comma seen: accept or reject the declared length
    function automatic void take_length();
        int len;
        if (len_neg || len_acc == 0)
        begin
            ph = DISCARD;
            return;
        end
        len = int'(len_acc);
        if (len >= BUF_SIZE_DEF)
            len = BUF_SIZE_DEF - 1;
        if (len == 0 || len > int'(cfg_max_len))
        begin
            ph = DISCARD;
            return;
        end
        frame_len = 8'(len);
        owed      = 8'(len);
        ph        = EMIT_BYTES;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void parse_char(rfp_in_t it);
        logic [7:0] c;
        c = it.line_char;
        if (it.end_of_line)
        begin
            if (ph == EMIT_BYTES && owed != 0)
                emit_payload(8'h00, 1'b0, 1'b1);
            clear_line();
            return;
        end
        // overlong line: the tail is dropped
        if (int'(chars_kept) >= LINE_MAX_DEF - 1)
            return;
        chars_kept = chars_kept + 8'd1;
        if (c == CHAR_NUL)
        begin
            if (ph == EMIT_BYTES && owed != 0)
                emit_payload(8'h00, 1'b0, 1'b1);
            ph   = DISCARD;
            owed = '0;
            return;
        end
        case (ph)
            SCAN_TAG:
            begin
                if (tag_idx < TAG_LEN && c == RCV_TAG[8*(4-int'(tag_idx)) +: 8])
                begin
                    tag_idx = tag_idx + 3'd1;
                    if (tag_idx == TAG_LEN)
                        ph = SKIP_ADDR;
                end
                else
                begin
                    ph = DISCARD;
                end
            end
            SKIP_ADDR:
            begin
                if (c == CHAR_COMMA)
                    ph = LEN_START;
            end
            LEN_START:
            begin
                if (is_blank(c))
                begin
                end
                else if (c == CHAR_PLUS || c == CHAR_MINUS)
                begin
                    len_neg = (c == CHAR_MINUS);
                    ph      = LEN_DIGITS;
                end
                else if (is_digit(c))
                begin
                    add_len_digit(c);
                    ph = LEN_DIGITS;
                end
                else
                begin
                    ph = SEEK_COMMA;
                    if (c == CHAR_COMMA)
                        take_length();
                end
            end
            LEN_DIGITS:
            begin
                if (is_digit(c))
                begin
                    add_len_digit(c);
                end
                else
                begin
                    ph = SEEK_COMMA;
                    if (c == CHAR_COMMA)
                        take_length();
                end
            end
            SEEK_COMMA:
            begin
                if (c == CHAR_COMMA)
                    take_length();
            end
            EMIT_BYTES:
            begin
                if (owed == 0)
                begin
                    ph = DISCARD;
                end
                else
                begin
                    owed = owed - 8'd1;
                    emit_payload(c, 1'b1, owed == 0);
                    if (owed == 0)
                        ph = DISCARD;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    //--------------------------------------------------------------------
    // Sender side
    //--------------------------------------------------------------------
    task automatic send_item(input logic [7:0] ch, input logic eol);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= {ch, eol};
        do
            @(posedge clk);
        while (!in_ready);
        parse_char(in_data);
        items_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_item(line_buf[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // stop offering, let every owed result out, then allow the pipe to settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_payload.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void add_random_bytes(int n, int lo, int hi);
        repeat (n) line_buf.push_back(8'($urandom_range(lo, hi)));
    endfunction

    function automatic void gen_line();
        int kind;
        int sel;
        int len_val;
        int eff;
        int count;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 72)
        begin
            add_text("+RCV=");
            add_random_bytes($urandom_range(0, 3), int'(CHAR_ZERO), int'(CHAR_NINE));
            line_buf.push_back(CHAR_COMMA);
            if ($urandom_range(0, 3) == 0)
                line_buf.push_back(($urandom_range(0, 5) == 0) ?
                                   CHAR_SPACE : 8'($urandom_range(9, 13)));
            sel = $urandom_range(0, 9);
            if (sel == 0)
                line_buf.push_back(CHAR_MINUS);
            else if (sel == 1)
                line_buf.push_back(CHAR_PLUS);
            sel = $urandom_range(0, 19);
            case (sel)
                0:       len_val = 0;
                1:       len_val = $urandom_range(256, 4095);
                2:       len_val = $urandom_range(4096, 99999999);
                3:       len_val = int'(cfg_max_len) + $urandom_range(0, 2) - 1;
                default: len_val = $urandom_range(1, 12);
            endcase
            if (sel == 4)
                add_text("00");
            // length with no digits at all
            if (sel != 5)
                add_text($sformatf("%0d", len_val));
            if ($urandom_range(0, 7) == 0)
                add_text("x");
            if ($urandom_range(0, 11) != 0)
                line_buf.push_back(CHAR_COMMA);
            eff = (len_val > 255) ? 255 : len_val;
            if (eff < 1 || eff > int'(cfg_max_len))
                count = $urandom_range(0, 6);
            else
                count = eff;
            sel = $urandom_range(0, 5);
            if (sel == 0)
                count = $urandom_range(0, count);
            else if (sel == 1)
                count += $urandom_range(1, 4);
            repeat (count)
                line_buf.push_back(($urandom_range(0, 39) == 0) ?
                                   CHAR_NUL : 8'($urandom_range(1, 255)));
        end
        else if (kind < 82)
        begin
            // prefix broken part way
            sel = $urandom_range(0, 4);
            for (int i = 0; i < sel; i++)
                line_buf.push_back(RCV_TAG[8*(4-i) +: 8]);
            add_random_bytes(1 + $urandom_range(0, 6), 0, 255);
        end
        else if (kind < 92)
        begin
            add_random_bytes($urandom_range(0, 12), 0, 255);
        end
        else
        begin
            add_text("+RCV=");
            add_random_bytes($urandom_range(0, 10), 32, 126);
        end
    endfunction

    //--------------------------------------------------------------------
    // Receiver side and result check
    //--------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        rfp_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_payload.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %p",
                         $time, out_data);
            end
            else
            begin
                want = pending_payload.pop_front();
                check_field("payload_byte", want.payload_byte, out_data.payload_byte);
                check_field("byte_valid", want.byte_valid, out_data.byte_valid);
                check_field("last", want.last, out_data.last);
                check_field("clamped_len", want.clamped_len, out_data.clamped_len);
            end
            rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
        end
    end

    // no transaction on either side for too long: give up
    always @(posedge clk)
    begin
        int quiet_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    //--------------------------------------------------------------------
    // Configuration
    //--------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [31:0] wdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MAX_PAYLOAD_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (!wr)
            check_field("prdata", wdata[7:0], prdata[7:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_max_payload(input logic [7:0] value);
        apb_access(1'b1, {24'h0, value});
        cfg_max_len = value;
        apb_access(1'b0, {24'h0, value});
    endtask

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------
    task automatic test_directed_frame();
        // one-byte frame carrying 0xFF
        line_buf.delete();
        add_text("+RCV=,1,");
        line_buf.push_back(8'hFF);
        send_line();
        // three owed, one sent, then a zero character cuts it short
        line_buf.delete();
        add_text("+RCV=,3,");
        line_buf.push_back(8'h80);
        line_buf.push_back(CHAR_NUL);
        send_line();
        line_buf.delete();
        line_buf.push_back(8'h7F);
        send_line();
        drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            gen_line();
            send_line();
            if ($urandom_range(0, 14) == 0)
                drain();
        end
        drain();
    endtask

    task automatic test_overlong_lines();
        // frame whose payload runs past the kept part of the line
        line_buf.delete();
        add_text("+RCV=7,250,");
        add_random_bytes(250, 1, 255);
        send_line();
        line_buf.delete();
        add_random_bytes(256, 0, 255);
        send_line();
        drain();
    endtask

    task automatic test_output_backpressure();
        set_max_payload(8'd200);
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        line_buf.delete();
        add_text("+RCV=3,100,");
        add_random_bytes(100, 1, 255);
        send_line();
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        items_sent  = 0;
        rx_wait     = 0;
        rx_hold_req = 1'b0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        cfg_max_len = MAX_PAYLOAD_RST;
        frame_len   = '0;
        clear_line();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frame();
        test_random_traffic(150);

        set_max_payload(8'd255);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_overlong_lines();
        test_random_traffic(100);

        set_max_payload(8'd1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random_traffic(100);

        set_max_payload(8'd0);
        test_random_traffic(40);

        set_max_payload(8'($urandom_range(2, 254)));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        test_random_traffic(100);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        test_random_traffic(100);

        test_output_backpressure();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rfp_pkg.sv
rtl/rfp_parser.sv
rtl/rfp_out_buf.sv
rtl/rcv_frame_payload_parser.sv
tb/sv/rcv_frame_payload_parser_tb.sv
